// ===== hw/rtl/plst_pkg.sv =====
// Shared types, codes and field widths for the positional list store.
`default_nettype none

package plst_pkg;

  // Default sizes handed to the top level parameters.
  localparam int DEF_MAX_ENTRIES = 16;
  localparam int DEF_VALUE_WIDTH = 32;

  // Fixed widths of the request and result fields.
  localparam int OP_W     = 4;
  localparam int WORD_W   = 32;
  localparam int POS_W    = 5;
  localparam int STATUS_W = 3;
  localparam int CNT_W    = 5;
  localparam int IN_W     = 80;
  localparam int OUT_W    = WORD_W + STATUS_W + CNT_W;

  // Operation codes carried in the request.
  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 4'd0,
    OP_INS_REAR  = 4'd1,
    OP_INS_AT    = 4'd2,
    OP_GET_FRONT = 4'd3,
    OP_GET_REAR  = 4'd4,
    OP_GET_AT    = 4'd5,
    OP_DEL_FRONT = 4'd6,
    OP_DEL_REAR  = 4'd7,
    OP_DEL_AT    = 4'd8,
    OP_DEL_VALUE = 4'd9,
    OP_REPLACE   = 4'd10,
    OP_REVERSE   = 4'd11
  } op_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_FULL     = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  // Controller sequence: take a request, capture match flags, execute.
  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_MATCH = 2'd1,
    S_EXEC  = 2'd2
  } state_t;

  // What every cell of the chain does in the current cycle.
  typedef enum logic [1:0] {
    CM_HOLD = 2'd0,
    CM_INS  = 2'd1,
    CM_DEL  = 2'd2,
    CM_WR   = 2'd3
  } cell_mode_t;

  // Broadcast command from the controller to the cells.
  typedef struct packed {
    cell_mode_t mode;
    logic       use_hit;
  } cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/plst_cell.sv =====
// One storage cell of the list chain: holds a word, shifts to and from its neighbors.
`default_nettype none

module plst_cell #(
  parameter int VW  = 32,
  parameter int CW  = 5,
  parameter int IDX = 0
) (
  input  wire                logic clk,
  input  wire plst_pkg::cmd_t      cmd,
  input  wire                logic [CW-1:0] q,
  input  wire                logic [CW-1:0] count,
  input  wire                logic [VW-1:0] key,
  input  wire                logic [VW-1:0] wdata,
  input  wire                logic          hit_at,
  input  wire                logic          hit_gt,
  input  wire                logic [VW-1:0] left_val,
  input  wire                logic [VW-1:0] right_val,
  output logic [VW-1:0] value,
  output logic          match,
  output logic [VW-1:0] rd
);
  import plst_pkg::*;

  localparam logic [CW-1:0] MyIdx = CW'(IDX);

  logic          at;
  logic          gt;
  logic [VW-1:0] value_next;

  // Locate this cell relative to the target: by index or by the match flags.
  assign at = cmd.use_hit ? hit_at : (q == MyIdx);
  assign gt = cmd.use_hit ? hit_gt : (q < MyIdx);

  // A live cell whose word equals the key reports a match.
  assign match = (MyIdx < count) && (value == key);

  // The addressed cell drives its word onto the read reduction.
  assign rd = at ? value : '0;

  // Next word: open a gap, close a gap, overwrite or hold.
  always_comb begin
    value_next = value;
    unique case (cmd.mode)
      CM_INS: begin
        if (gt) begin
          value_next = left_val;
        end else if (at) begin
          value_next = wdata;
        end
      end
      CM_DEL: begin
        if (gt || at) begin
          value_next = right_val;
        end
      end
      CM_WR: begin
        if (at) begin
          value_next = wdata;
        end
      end
      default: value_next = value;
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/plst_ctrl.sv =====
// Request decode, count and direction tracking, and result register of the list store.
`default_nettype none

module plst_ctrl #(
  parameter int N  = 16,
  parameter int VW = 32,
  parameter int CW = 5
) (
  input  wire  logic                     clk,
  input  wire  logic                     rst,
  input  wire  logic                     s_tvalid,
  output logic                           s_tready,
  input  wire  logic [plst_pkg::IN_W-1:0] s_tdata,
  output logic                           m_tvalid,
  input  wire  logic                     m_tready,
  output logic [plst_pkg::OUT_W-1:0]     m_tdata,
  output plst_pkg::cmd_t                 cmd,
  output logic [CW-1:0]                  q,
  output logic [CW-1:0]                  count,
  output logic [VW-1:0]                  key,
  output logic [VW-1:0]                  wdata,
  output logic [N-1:0]                   hit_at,
  output logic [N-1:0]                   hit_gt,
  input  wire  logic [N-1:0]             match_vec,
  input  wire  logic [VW-1:0]            rd_val
);
  import plst_pkg::*;

  localparam int PW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] FullCount = CW'(N);

  state_t              state;
  state_t              state_next;
  op_t                 op_r;
  logic [VW-1:0]       repl_r;
  logic [POS_W-1:0]    pos_r;
  logic                rev;
  logic [N-1:0]        hit_m;
  logic                out_valid;
  logic [OUT_W-1:0]    out_data;

  logic                accept;
  logic                capture;
  logic                go;

  logic signed [63:0]  item_ext;
  logic signed [63:0]  repl_ext;
  logic [CW-1:0]       pos_c;
  logic [PW-1:0]       pos_w;
  logic [PW-1:0]       n_w;
  logic [CW-1:0]       ins_log;
  logic [CW-1:0]       get_log;
  logic                is_ins;
  logic [CW-1:0]       q_next;

  logic [N-1:0]        hit_rv;
  logic [N-1:0]        first_rv;
  logic [N-1:0]        first_hit;
  logic [N-1:0]        last_hit;
  logic [N-1:0]        sel_hit;

  cell_mode_t          mode_x;
  logic                use_hit_x;
  status_t             status_x;
  logic [WORD_W-1:0]   read_x;
  logic [CW-1:0]       count_next;
  logic                rev_next;
  logic signed [VW-1:0] rd_s;
  logic signed [63:0]  rd_ext;

  // Incoming values are sign extended from the field and kept at the stored width.
  assign item_ext = 64'(signed'(s_tdata[35:4]));
  assign repl_ext = 64'(signed'(s_tdata[72:41]));

  // Controller sequence.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (s_tvalid) state_next = S_MATCH;
      S_MATCH: state_next = S_EXEC;
      S_EXEC:  if (!out_valid || m_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    capture  = 1'b0;
    go       = 1'b0;
    unique case (state)
      S_IDLE:  s_tready = 1'b1;
      S_MATCH: capture = 1'b1;
      S_EXEC:  go = !out_valid || m_tready;
      default: s_tready = 1'b0;
    endcase
  end

  assign accept = s_tvalid && s_tready;

  // Logical position of the request, then its physical cell under the direction flag.
  assign pos_c = CW'(pos_r);
  assign pos_w = PW'(pos_r);
  assign n_w   = PW'(count);
  assign is_ins = (op_r == OP_INS_FRONT) || (op_r == OP_INS_REAR) || (op_r == OP_INS_AT);

  always_comb begin
    ins_log = pos_c;
    get_log = (pos_w < n_w) ? pos_c : (count - CW'(1));
    if (op_r == OP_INS_FRONT) begin
      ins_log = '0;
    end else if (op_r == OP_INS_REAR) begin
      ins_log = count;
    end
    if ((op_r == OP_GET_FRONT) || (op_r == OP_DEL_FRONT)) begin
      get_log = '0;
    end else if ((op_r == OP_GET_REAR) || (op_r == OP_DEL_REAR)) begin
      get_log = count - CW'(1);
    end
    if (is_ins) begin
      q_next = rev ? (count - ins_log) : ins_log;
    end else begin
      q_next = rev ? (count - CW'(1) - get_log) : get_log;
    end
  end

  // First match in list order: lowest live cell, or highest when reversed.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      hit_rv[i]   = hit_m[N-1-i];
      last_hit[i] = first_rv[N-1-i];
    end
  end

  assign first_hit = hit_m & (~hit_m + N'(1));
  assign first_rv  = hit_rv & (~hit_rv + N'(1));
  assign sel_hit   = rev ? last_hit : first_hit;
  assign hit_at    = sel_hit;
  assign hit_gt    = ~((sel_hit - N'(1)) | sel_hit);

  // Stored word sign extended and cut to the result field.
  assign rd_s   = signed'(rd_val);
  assign rd_ext = 64'(rd_s);

  // Decide the operation's effect and its result.
  always_comb begin
    mode_x     = CM_HOLD;
    use_hit_x  = 1'b0;
    status_x   = ST_OK;
    read_x     = '0;
    count_next = count;
    rev_next   = rev;
    wdata      = key;
    unique case (op_r)
      OP_INS_FRONT, OP_INS_REAR, OP_INS_AT: begin
        if ((op_r == OP_INS_AT) && (pos_w > n_w)) begin
          status_x = ST_BADPOS;
        end else if (count == FullCount) begin
          status_x = ST_FULL;
        end else begin
          mode_x     = CM_INS;
          count_next = count + CW'(1);
        end
      end
      OP_GET_FRONT, OP_GET_REAR, OP_GET_AT,
      OP_DEL_FRONT, OP_DEL_REAR, OP_DEL_AT: begin
        if (count == '0) begin
          status_x = ST_EMPTY;
        end else if (((op_r == OP_GET_AT) || (op_r == OP_DEL_AT)) && (pos_w > n_w)) begin
          status_x = ST_BADPOS;
        end else if ((op_r == OP_GET_FRONT) || (op_r == OP_GET_REAR) ||
                     (op_r == OP_GET_AT)) begin
          read_x = rd_ext[WORD_W-1:0];
        end else begin
          mode_x     = CM_DEL;
          count_next = count - CW'(1);
        end
      end
      OP_DEL_VALUE, OP_REPLACE: begin
        use_hit_x = 1'b1;
        if (count == '0) begin
          status_x = ST_EMPTY;
        end else if (hit_m == '0) begin
          status_x = ST_NOTFOUND;
        end else if (op_r == OP_DEL_VALUE) begin
          mode_x     = CM_DEL;
          count_next = count - CW'(1);
        end else begin
          mode_x = CM_WR;
          wdata  = repl_r;
        end
      end
      OP_REVERSE: rev_next = !rev;
      default: status_x = ST_OK;
    endcase
  end

  assign cmd.mode    = go ? mode_x : CM_HOLD;
  assign cmd.use_hit = use_hit_x;

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rev       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (go) begin
        count     <= count_next;
        rev       <= rev_next;
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request fields, match flags, target cell and result word.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= op_t'(s_tdata[3:0]);
      key    <= item_ext[VW-1:0];
      repl_r <= repl_ext[VW-1:0];
      pos_r  <= s_tdata[40:36];
    end
    if (capture) begin
      hit_m <= match_vec;
      q     <= q_next;
    end
    if (go) begin
      out_data <= {CNT_W'(count_next), status_x, read_x};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule

`default_nettype wire

// ===== hw/rtl/positional_list_store_top.sv =====
// Top level of the positional list store: a chain of word cells under one controller.
// Sequence: a request is accepted and registered, its match flags and target cell are captured,
// and the result register loads in the execute step; the next request is accepted only after
// that, back in idle. A waiting result stalls only the execute step.
// Reset: synchronous, active high; clears the entry count, direction and result valid.
// Cell contents are not reset and are only read below the entry count.
`default_nettype none

module positional_list_store_top #(
  parameter int MAX_ENTRIES = plst_pkg::DEF_MAX_ENTRIES,
  parameter int VALUE_WIDTH = plst_pkg::DEF_VALUE_WIDTH
) (
  input  wire  logic                       clk,
  input  wire  logic                       rst,
  input  wire  logic                       s_tvalid,
  output logic                             s_tready,
  // op[3:0], item_value[35:4], position[40:36], new_value[72:41], zero pad[79:73]
  input  wire  logic [plst_pkg::IN_W-1:0]  s_tdata,
  output logic                             m_tvalid,
  input  wire  logic                       m_tready,
  // read_value[31:0], status[34:32], count_out[39:35]
  output logic [plst_pkg::OUT_W-1:0]       m_tdata
);
  import plst_pkg::*;

  localparam int N  = MAX_ENTRIES;
  localparam int VW = VALUE_WIDTH;
  localparam int CW = $clog2(N + 1);

  cmd_t            cmd;
  logic [CW-1:0]   q;
  logic [CW-1:0]   count;
  logic [VW-1:0]   key;
  logic [VW-1:0]   wdata;
  logic [N-1:0]    hit_at;
  logic [N-1:0]    hit_gt;
  logic [N-1:0]    match_vec;
  logic [VW-1:0]   cell_val [N];
  logic [VW-1:0]   cell_rd  [N];
  logic [VW-1:0]   rd_val;

  plst_ctrl #(
    .N  (N),
    .VW (VW),
    .CW (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .q         (q),
    .count     (count),
    .key       (key),
    .wdata     (wdata),
    .hit_at    (hit_at),
    .hit_gt    (hit_gt),
    .match_vec (match_vec),
    .rd_val    (rd_val)
  );

  // The cell chain; the front cell's left input and the rear cell's right input are ends.
  for (genvar i = 0; i < N; i++) begin : g_cell
    plst_cell #(
      .VW  (VW),
      .CW  (CW),
      .IDX (i)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .q         (q),
      .count     (count),
      .key       (key),
      .wdata     (wdata),
      .hit_at    (hit_at[i]),
      .hit_gt    (hit_gt[i]),
      .left_val  ((i == 0) ? wdata : cell_val[(i == 0) ? 0 : i - 1]),
      .right_val ((i == N - 1) ? cell_val[i] : cell_val[(i == N - 1) ? i : i + 1]),
      .value     (cell_val[i]),
      .match     (match_vec[i]),
      .rd        (cell_rd[i])
    );
  end

  // Only the addressed cell drives a nonzero word, so the read is an OR over the chain.
  always_comb begin
    rd_val = '0;
    for (int i = 0; i < N; i++) begin
      rd_val = rd_val | cell_rd[i];
    end
  end

`ifndef SYNTH
  // One request at a time: an accepted request closes the input until it finishes.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request accepted while another is in flight");

  // A fresh result never appears right after an accept.
  a_result_delay: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
    else $error("result appeared too soon after a request");

  // An empty-list result carries no read word and an empty count.
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[34:32] == ST_EMPTY)) |-> ((m_tdata[31:0] == '0) &&
                                                     (m_tdata[39:35] == '0)))
    else $error("empty status with nonzero data or count");

  // Status codes stay within the defined set.
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[34:32] == ST_OK) || (m_tdata[34:32] == ST_EMPTY) ||
                  (m_tdata[34:32] == ST_FULL) || (m_tdata[34:32] == ST_BADPOS) ||
                  (m_tdata[34:32] == ST_NOTFOUND)))
    else $error("undefined status code in result");
`endif

endmodule

`default_nettype wire
